### rtl/bsi_pkg.sv
// Package for the blend segment interpolator: shared types, constants and codes.
// Used by bsi_ctrl, bsi_datapath and blend_segment_interpolator.
package bsi_pkg;

   localparam int MaxSamplesDefault = 16;
   localparam int FracBitsDefault   = 16;
   localparam int WeightBits        = 17;
   localparam int WeightFrac        = 16;

   localparam logic [0:0] CmdWrite = 1'b0;
   localparam logic [0:0] CmdEval  = 1'b1;

   localparam logic [1:0] RegMotionKind  = 2'd0;
   localparam logic [1:0] RegSingleClip  = 2'd1;
   localparam logic [1:0] RegSinglePres  = 2'd2;
   localparam logic [1:0] RegSampleCount = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_FIRST,
      ST_READ_LAST,
      ST_CHECK,
      ST_SEARCH,
      ST_READ_LEFT,
      ST_READ_RIGHT,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;     // latch input item
      logic write_table; // write sample to table
      logic rd_first;    // read slot 0
      logic rd_last;     // read slot n-1
      logic rd_mid;      // read search probe
      logic rd_left;     // read slot j-1
      logic rd_right;    // read slot j
      logic lat_first;   // latch slot 0 data
      logic lat_last;    // latch slot n-1 data
      logic lat_left;    // latch left data
      logic lat_right;   // latch right data
      logic search_init;
      logic search_step;
      logic div_start;
      logic div_step;
      logic mul_step;
      logic out_clip;
      logic out_empty;
      logic out_first;
      logic out_last;
      logic out_pair;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_eval;
      logic clip_mode;
      logic empty;
      logic one_sample;
      logic below_first;
      logic above_last;
      logic search_done;
      logic div_done;
   } status_type;

endpackage

### rtl/bsi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsi_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bsi_ctrl.sv
// Controller state machine for the blend segment interpolator.
// Depends on bsi_pkg for state, command and status types.
module bsi_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bsi_pkg::status_type status,
   output bsi_pkg::cmd_type    cmd
);

   bsi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bsi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = bsi_pkg::ST_READ_FIRST;
            end
         end
         bsi_pkg::ST_READ_FIRST: begin
            // captured item now visible
            if (!status.is_eval) begin
               cmd.write_table = 1'b1;
               state_in        = bsi_pkg::ST_IDLE;
            end else if (status.clip_mode) begin
               cmd.out_clip = 1'b1;
               state_in     = bsi_pkg::ST_OUTPUT;
            end else if (status.empty) begin
               cmd.out_empty = 1'b1;
               state_in      = bsi_pkg::ST_OUTPUT;
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = bsi_pkg::ST_READ_LAST;
            end
         end
         bsi_pkg::ST_READ_LAST: begin
            cmd.lat_first = 1'b1;
            cmd.rd_last   = 1'b1;
            state_in      = bsi_pkg::ST_CHECK;
         end
         bsi_pkg::ST_CHECK: begin
            cmd.lat_last = 1'b1;
            if (status.one_sample || status.below_first) begin
               cmd.out_first = 1'b1;
               state_in      = bsi_pkg::ST_OUTPUT;
            end else if (status.above_last) begin
               cmd.out_last = 1'b1;
               state_in     = bsi_pkg::ST_OUTPUT;
            end else begin
               cmd.search_init = 1'b1;
               cmd.rd_mid      = 1'b1;
               state_in        = bsi_pkg::ST_SEARCH;
            end
         end
         bsi_pkg::ST_SEARCH: begin
            if (status.search_done) begin
               cmd.rd_left = 1'b1;
               state_in    = bsi_pkg::ST_READ_LEFT;
            end else begin
               cmd.search_step = 1'b1;
               cmd.rd_mid      = 1'b1;
            end
         end
         bsi_pkg::ST_READ_LEFT: begin
            cmd.lat_left = 1'b1;
            cmd.rd_right = 1'b1;
            state_in     = bsi_pkg::ST_READ_RIGHT;
         end
         bsi_pkg::ST_READ_RIGHT: begin
            cmd.lat_right = 1'b1;
            state_in      = bsi_pkg::ST_DIVIDE;
         end
         bsi_pkg::ST_DIVIDE: begin
            cmd.div_start = 1'b1;
            state_in      = bsi_pkg::ST_MULTIPLY;
         end
         bsi_pkg::ST_MULTIPLY: begin
            if (status.div_done) begin
               cmd.mul_step = 1'b1;
               state_in     = bsi_pkg::ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         bsi_pkg::ST_FINISH: begin
            cmd.out_pair = 1'b1;
            state_in     = bsi_pkg::ST_OUTPUT;
         end
         bsi_pkg::ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = bsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsi_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/bsi_datapath.sv
// Datapath: sample table, linear threshold scan, restoring divider, speed multiply.
// Depends on bsi_pkg and bsi_ram.
module bsi_datapath #(
   parameter int MaxSamples = bsi_pkg::MaxSamplesDefault,
   parameter int FracBits   = bsi_pkg::FracBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  bsi_pkg::cmd_type    cmd,
   output bsi_pkg::status_type status,
   // captured request fields
   input  logic                req_cmd,
   input  logic [3:0]          req_entry_index,
   input  logic signed [31:0]  req_entry_threshold,
   input  logic signed [31:0]  req_entry_speed,
   input  logic [15:0]         req_entry_clip_id,
   input  logic                req_entry_clip_present,
   input  logic signed [31:0]  req_blend_value,
   input  logic                req_value_present,
   // configuration
   input  logic                cfg_motion_kind,
   input  logic [15:0]         cfg_single_clip_id,
   input  logic                cfg_single_clip_present,
   input  logic [4:0]          cfg_sample_count,
   // result
   output logic                rsp_result_valid,
   output logic [15:0]         rsp_primary_clip,
   output logic [15:0]         rsp_secondary_clip,
   output logic [16:0]         rsp_secondary_weight,
   output logic signed [31:0]  rsp_speed_scale,
   output logic signed [31:0]  rsp_lower_threshold,
   output logic signed [31:0]  rsp_upper_threshold,
   output logic signed [31:0]  rsp_used_value
);

   localparam int AddrBits  = $clog2(MaxSamples);
   localparam int CntBits   = $clog2(MaxSamples + 1);
   localparam int EntryBits = 32 + 32 + 16 + 1;
   localparam int WOne      = 1 << bsi_pkg::WeightFrac;
   localparam int SpanEps   = (1 << FracBits) / 100000;
   localparam int DivSteps  = 32 + bsi_pkg::WeightFrac;
   localparam int DivCntW   = $clog2(DivSteps + 1);
   localparam logic signed [31:0] OneQ = 32'(1 << FracBits);

   // captured item
   logic              cmd_ff;
   logic [3:0]        idx_ff;
   logic [31:0]       wthr_ff, wspd_ff;
   logic [15:0]       wclip_ff;
   logic              wpres_ff;
   logic signed [31:0] val_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_cmd;
         idx_ff   <= req_entry_index;
         wthr_ff  <= req_entry_threshold;
         wspd_ff  <= req_entry_speed;
         wclip_ff <= req_entry_clip_id;
         wpres_ff <= req_entry_clip_present;
         val_ff   <= req_value_present ? req_blend_value : 32'sd0;
      end
   end

   // effective sample count, clamped
   logic [CntBits-1:0] n_eff;
   always_comb begin
      if (32'(cfg_sample_count) > 32'(MaxSamples)) begin
         n_eff = CntBits'(MaxSamples);
      end else begin
         n_eff = CntBits'(cfg_sample_count);
      end
   end
   logic [AddrBits-1:0] last_addr;
   assign last_addr = AddrBits'(n_eff - CntBits'(1));

   // scan position: slot whose data is on the RAM output while scanning
   logic [AddrBits-1:0] scan_ff;

   // table RAM
   logic                 ram_we;
   logic [AddrBits-1:0]  ram_waddr, ram_raddr;
   logic [EntryBits-1:0] ram_wdata, ram_rdata;
   logic                 idx_in_range;

   assign idx_in_range = 32'(idx_ff) < 32'(MaxSamples);
   assign ram_we       = cmd.write_table && idx_in_range;
   assign ram_waddr    = AddrBits'(idx_ff);
   assign ram_wdata    = {wthr_ff, wspd_ff, wclip_ff, wpres_ff};

   always_comb begin
      ram_raddr = '0;
      if (cmd.rd_last) begin
         ram_raddr = last_addr;
      end else if (cmd.rd_mid) begin
         ram_raddr = cmd.search_init ? AddrBits'(1) : scan_ff + AddrBits'(1);
      end else if (cmd.rd_left) begin
         ram_raddr = scan_ff - AddrBits'(1);
      end else if (cmd.rd_right) begin
         ram_raddr = scan_ff;
      end
   end

   bsi_ram #(.Width(EntryBits), .Depth(MaxSamples)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   logic signed [31:0] rd_thr, rd_spd;
   logic [15:0]        rd_clip;
   logic               rd_pres;
   assign {rd_thr, rd_spd, rd_clip, rd_pres} = ram_rdata;

   // end samples and pair
   logic signed [31:0] a_thr_ff, a_spd_ff, b_thr_ff, b_spd_ff;
   logic [15:0]        a_clip_ff, b_clip_ff;
   logic               a_pres_ff, b_pres_ff;

   always_ff @(posedge clock) begin
      if (cmd.lat_first || cmd.lat_left) begin
         a_thr_ff  <= rd_thr;
         a_spd_ff  <= rd_spd;
         a_clip_ff <= rd_clip;
         a_pres_ff <= rd_pres;
      end
      if (cmd.lat_last || cmd.lat_right) begin
         b_thr_ff  <= rd_thr;
         b_spd_ff  <= rd_spd;
         b_clip_ff <= rd_clip;
         b_pres_ff <= rd_pres;
      end
   end

   // scan slots 1..n-1 in order; the next slot is read while the current one is compared
   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         scan_ff <= AddrBits'(1);
      end else if (cmd.search_step) begin
         scan_ff <= scan_ff + AddrBits'(1);
      end
   end

   // stop at the lowest slot whose threshold exceeds the value, or at slot n-1
   logic search_done;
   assign search_done = (rd_thr > val_ff) || (scan_ff == last_addr);

   // restoring divider: diff << 16 / span
   logic [63:0]        rem_ff;
   logic [47:0]        quo_ff;
   logic [32:0]        div_ff;
   logic [DivCntW-1:0] dcnt_ff;
   logic               wone_ff, wzero_ff;
   logic signed [32:0] span_w, diff_w;
   logic [64:0]        trial;

   assign span_w = 33'(b_thr_ff) - 33'(a_thr_ff);
   assign diff_w = 33'(val_ff) - 33'(a_thr_ff);
   assign trial  = {rem_ff, quo_ff[47]} - {32'd0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         wone_ff  <= !(span_w > 33'sd0 && span_w > 33'(SpanEps));
         wzero_ff <= diff_w <= 33'sd0;
         rem_ff   <= '0;
         quo_ff   <= {15'd0, diff_w[32:0]} << bsi_pkg::WeightFrac;
         div_ff   <= span_w[32:0];
         dcnt_ff  <= DivCntW'(DivSteps);
      end else if (cmd.div_step) begin
         if (!trial[64]) begin
            rem_ff <= trial[63:0];
            quo_ff <= {quo_ff[46:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[62:0], quo_ff[47]};
            quo_ff <= {quo_ff[46:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - DivCntW'(1);
      end
   end

   logic div_done;
   assign div_done = dcnt_ff == '0;

   logic [16:0] weight;
   always_comb begin
      if (wone_ff) begin
         weight = 17'(WOne);
      end else if (wzero_ff) begin
         weight = '0;
      end else if (quo_ff > 48'(WOne)) begin
         weight = 17'(WOne);
      end else begin
         weight = quo_ff[16:0];
      end
   end

   // speed interpolation: 33 x 18 product
   logic signed [32:0] step_w;
   logic signed [50:0] prod_ff;
   logic [16:0]        weight_ff;
   assign step_w = 33'(b_spd_ff) - 33'(a_spd_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         prod_ff   <= 51'(step_w) * $signed({1'b0, weight});
         weight_ff <= weight;
      end
   end

   // floor toward minus infinity via arithmetic shift
   logic signed [31:0] interp_spd;
   assign interp_spd = 32'(a_spd_ff + 32'(prod_ff >>> bsi_pkg::WeightFrac));

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_clip) begin
         rsp_result_valid     <= cfg_single_clip_present;
         rsp_primary_clip     <= cfg_single_clip_id;
         rsp_secondary_clip   <= '0;
         rsp_secondary_weight <= '0;
         rsp_speed_scale      <= OneQ;
         rsp_lower_threshold  <= '0;
         rsp_upper_threshold  <= '0;
         rsp_used_value       <= '0;
      end else if (cmd.out_empty) begin
         rsp_result_valid     <= 1'b0;
         rsp_primary_clip     <= '0;
         rsp_secondary_clip   <= '0;
         rsp_secondary_weight <= '0;
         rsp_speed_scale      <= OneQ;
         rsp_lower_threshold  <= '0;
         rsp_upper_threshold  <= '0;
         rsp_used_value       <= '0;
      end else if (cmd.out_first || cmd.out_last) begin
         rsp_result_valid     <= cmd.out_first ? a_pres_ff : rd_pres;
         rsp_primary_clip     <= cmd.out_first ? a_clip_ff : rd_clip;
         rsp_secondary_clip   <= '0;
         rsp_secondary_weight <= '0;
         rsp_speed_scale      <= cmd.out_first ? a_spd_ff : rd_spd;
         rsp_lower_threshold  <= cmd.out_first ? a_thr_ff : rd_thr;
         rsp_upper_threshold  <= cmd.out_first ? a_thr_ff : rd_thr;
         rsp_used_value       <= val_ff;
      end else if (cmd.out_pair) begin
         rsp_result_valid     <= a_pres_ff & b_pres_ff;
         rsp_primary_clip     <= a_clip_ff;
         rsp_secondary_clip   <= b_clip_ff;
         rsp_secondary_weight <= weight_ff;
         rsp_speed_scale      <= interp_spd;
         rsp_lower_threshold  <= a_thr_ff;
         rsp_upper_threshold  <= b_thr_ff;
         rsp_used_value       <= val_ff;
      end
   end

   // status; last sample data is on the RAM output during ST_CHECK
   assign status.is_eval     = cmd_ff == bsi_pkg::CmdEval;
   assign status.clip_mode   = !cfg_motion_kind;
   assign status.empty       = n_eff == '0;
   assign status.one_sample  = n_eff == CntBits'(1);
   assign status.below_first = val_ff <= a_thr_ff;
   assign status.above_last  = val_ff >= rd_thr;
   assign status.search_done = search_done;
   assign status.div_done    = div_done;

endmodule

### rtl/blend_segment_interpolator.sv
// Top level of the blend segment interpolator: APB register file plus
// controller (bsi_ctrl) and datapath (bsi_datapath); uses bsi_pkg.
//
//  channel  direction  handshake        payload
//  req_     in         req_valid/ready  cmd, entry fields, blend value
//  rsp_     out        rsp_valid/ready  clips, weight, speed, thresholds, value
//  csr_     in/out     psel/penable     motion kind, single clip, sample count
//
// A write item, a clip-mode or edge evaluation skips the scan and divider;
// an interior evaluation scans slots from 1 up to at most MaxSamples-1 in
// order, then runs the restoring divider, one quotient bit a cycle.
// The result waits in the output register until taken; no new item is
// accepted meanwhile. Reset clears the configuration registers, the
// divider count and the controller; the table is undefined until written.
module blend_segment_interpolator #(
   parameter int MaxSamples = bsi_pkg::MaxSamplesDefault,
   parameter int FracBits   = bsi_pkg::FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [3:0]         req_entry_index,
   input  logic signed [31:0] req_entry_threshold,
   input  logic signed [31:0] req_entry_speed,
   input  logic [15:0]        req_entry_clip_id,
   input  logic               req_entry_clip_present,
   input  logic signed [31:0] req_blend_value,
   input  logic               req_value_present,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_result_valid,
   output logic [15:0]        rsp_primary_clip,
   output logic [15:0]        rsp_secondary_clip,
   output logic [16:0]        rsp_secondary_weight,
   output logic signed [31:0] rsp_speed_scale,
   output logic signed [31:0] rsp_lower_threshold,
   output logic signed [31:0] rsp_upper_threshold,
   output logic signed [31:0] rsp_used_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic        motion_kind_ff;
   logic [15:0] single_clip_ff;
   logic        single_pres_ff;
   logic [4:0]  sample_count_ff;
   logic [1:0]  reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_kind_ff  <= 1'b0;
         single_clip_ff  <= '0;
         single_pres_ff  <= 1'b0;
         sample_count_ff <= '0;
      end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
         case (reg_sel)
            bsi_pkg::RegMotionKind:  motion_kind_ff  <= pwdata[0];
            bsi_pkg::RegSingleClip:  single_clip_ff  <= pwdata[15:0];
            bsi_pkg::RegSinglePres:  single_pres_ff  <= pwdata[0];
            bsi_pkg::RegSampleCount: sample_count_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         bsi_pkg::RegMotionKind:  prdata = {31'd0, motion_kind_ff};
         bsi_pkg::RegSingleClip:  prdata = {16'd0, single_clip_ff};
         bsi_pkg::RegSinglePres:  prdata = {31'd0, single_pres_ff};
         bsi_pkg::RegSampleCount: prdata = {27'd0, sample_count_ff};
         default:                 prdata = '0;
      endcase
   end

   bsi_pkg::cmd_type    cmd;
   bsi_pkg::status_type status;

   bsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsi_datapath #(.MaxSamples(MaxSamples), .FracBits(FracBits)) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_cmd                 (req_cmd),
      .req_entry_index         (req_entry_index),
      .req_entry_threshold     (req_entry_threshold),
      .req_entry_speed         (req_entry_speed),
      .req_entry_clip_id       (req_entry_clip_id),
      .req_entry_clip_present  (req_entry_clip_present),
      .req_blend_value         (req_blend_value),
      .req_value_present       (req_value_present),
      .cfg_motion_kind         (motion_kind_ff),
      .cfg_single_clip_id      (single_clip_ff),
      .cfg_single_clip_present (single_pres_ff),
      .cfg_sample_count        (sample_count_ff),
      .rsp_result_valid        (rsp_result_valid),
      .rsp_primary_clip        (rsp_primary_clip),
      .rsp_secondary_clip      (rsp_secondary_clip),
      .rsp_secondary_weight    (rsp_secondary_weight),
      .rsp_speed_scale         (rsp_speed_scale),
      .rsp_lower_threshold     (rsp_lower_threshold),
      .rsp_upper_threshold     (rsp_upper_threshold),
      .rsp_used_value          (rsp_used_value)
   );

endmodule
